// File: design/rar_pkg.sv
// Package: widths, codes and reset values shared by the range-add range-max tree.
`timescale 1ns / 1ps
package rar_pkg;
    localparam int POS_W     = 17;
    localparam int VAL_IN_W  = 31;
    localparam int VAL_W     = 48;
    localparam int MAX_POSITIONS_DEF = 65536;
    localparam logic [POS_W-1:0] ARRAY_SIZE_RESET = 17'd65536;
    localparam logic OP_ADD = 1'b0;
    localparam logic OP_MAX = 1'b1;
    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

    // saturating add of a non-negative amount to a node value
    function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W:0] b);
        logic [VAL_W+1:0] s;
        s = {2'b00, a} + {1'b0, b};
        sat_add = (s > {2'b00, VAL_MAX}) ? VAL_MAX : s[VAL_W-1:0];
    endfunction
endpackage

// File: design/range_add_range_max_tree_top.sv
// Top level: segment tree with lazy additions, range add and range max.
//
//  channel  | ports                                        | handshake
//  ---------+----------------------------------------------+---------------------------
//  command  | i_opcode i_range_low i_range_high i_add_value | start high, busy low
//  result   | o_max_value                                  | o_valid, one cycle
//  config   | i_cfg_wdata (array_size)                     | i_cfg_we, no wait
//
// One item walks the tree depth first with an explicit stack; each node visit is a
// read-modify-write on the node memory, with both children updated too when pending
// values go down to them, plus a return step and a merge at each split node; the one
// node memory port pair sets the pace. After reset a clearing pass writes all
// 4*MAX_POSITIONS node entries, one per cycle, with busy high.
// Results cannot be stalled.
`timescale 1ns / 1ps
module range_add_range_max_tree_top #(
    parameter int MAX_POSITIONS = rar_pkg::MAX_POSITIONS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_opcode,
    input  logic [rar_pkg::POS_W-1:0]    i_range_low,
    input  logic [rar_pkg::POS_W-1:0]    i_range_high,
    input  logic [rar_pkg::VAL_IN_W-1:0] i_add_value,
    output logic                        o_valid,
    output logic [rar_pkg::VAL_W-1:0]    o_max_value,
    input  logic                        i_cfg_we,
    input  logic [rar_pkg::POS_W-1:0]    i_cfg_wdata
);
    localparam int VW  = rar_pkg::VAL_W;
    localparam int PW  = rar_pkg::POS_W;
    localparam int NC  = 4 * MAX_POSITIONS;
    localparam int AW  = $clog2(NC);
    localparam int MPW = $clog2(MAX_POSITIONS + 1);
    localparam int LW  = (MPW > PW) ? MPW : PW;
    localparam int SIW = $clog2(AW + 1);
    localparam int SD  = 2 ** SIW;
    localparam logic [AW:0] NC_V  = (AW+1)'(NC);
    localparam logic [LW-1:0] MAX_V = LW'(MAX_POSITIONS);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_VISIT, S_K_WAIT, S_KID_L, S_KID_LW, S_KID_RW, S_WRK, S_RET
    } t_state;

    t_state r_state;

    // node memory: {node max, pending add}
    logic [2*VW-1:0] r_mem [NC];
    logic [2*VW-1:0] r_rd;
    logic            mem_we, mem_re;
    logic [AW-1:0]   mem_wa, mem_ra;
    logic [2*VW-1:0] mem_wd;

    // traversal stack of parent frames
    logic [AW-1:0] r_stk_k    [SD];
    logic [LW-1:0] r_stk_lo   [SD];
    logic [LW-1:0] r_stk_hi   [SD];
    logic          r_stk_flag [SD];
    logic [VW-1:0] r_stk_acc  [SD];
    logic [SIW-1:0] r_sp;

    logic [PW-1:0]  r_array_size;
    logic           r_op;
    logic [LW-1:0]  r_a, r_b;
    logic [VW-1:0]  r_v;
    logic [AW-1:0]  r_k;
    logic [LW-1:0]  r_lo, r_hi;
    logic [VW-1:0]  r_nm1, r_ret;
    logic [VW:0]    r_c;
    logic           r_out, r_cover, r_split;
    logic [AW-1:0]  r_clr;

    // per-node decode
    logic [VW-1:0] nm_rd, pd_rd, nm1, nm_fin;
    logic [AW:0]   k2p1;
    logic          split, out_c, cover_c, kids;
    logic [VW:0]   c_amt;
    logic [LW:0]   mid_sum;
    logic [LW-1:0] mid;
    logic [LW-1:0] used_n;

    // parent frame at stack top
    logic [SIW-1:0] sp_m1;
    logic [AW-1:0]  p_k;
    logic [LW-1:0]  p_lo, p_hi, p_mid;
    logic [LW:0]    p_sum;
    logic [VW-1:0]  p_max;

    assign busy  = (r_state != S_IDLE);
    assign nm_rd = r_rd[2*VW-1:VW];
    assign pd_rd = r_rd[VW-1:0];
    assign nm1   = (pd_rd != '0) ? rar_pkg::sat_add(nm_rd, {1'b0, pd_rd}) : nm_rd;
    assign k2p1  = {r_k, 1'b1};
    assign split = (k2p1 < NC_V);
    assign out_c   = (r_hi < r_a) || (r_b < r_lo);
    assign cover_c = (r_a <= r_lo) && (r_hi <= r_b);
    assign kids    = (r_lo < r_hi) && split;
    assign c_amt   = {1'b0, pd_rd}
                   + ((r_op == rar_pkg::OP_ADD && cover_c && !out_c) ?
                      {1'b0, r_v} : '0);
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = mid_sum[LW:1];
    assign nm_fin  = (r_op == rar_pkg::OP_ADD && r_cover && !r_out) ?
                     rar_pkg::sat_add(r_nm1, {1'b0, r_v}) : r_nm1;

    assign sp_m1 = r_sp - 1'b1;
    assign p_k   = r_stk_k[sp_m1];
    assign p_lo  = r_stk_lo[sp_m1];
    assign p_hi  = r_stk_hi[sp_m1];
    assign p_sum = {1'b0, p_lo} + {1'b0, p_hi};
    assign p_mid = p_sum[LW:1];
    assign p_max = (r_stk_acc[sp_m1] > r_ret) ? r_stk_acc[sp_m1] : r_ret;

    // effective size: zero means one, clamp to capacity
    always_comb begin
        used_n = LW'(r_array_size);
        if (r_array_size == '0) used_n = LW'(1);
        if (LW'(r_array_size) > MAX_V) used_n = MAX_V;
    end

    // memory port control
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_k;
        mem_wd = '0;
        mem_re = 1'b0;
        mem_ra = r_k;
        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
            end
            S_VISIT: begin
                mem_re = 1'b1;
            end
            S_KID_L: begin
                mem_re = 1'b1;
                mem_ra = {r_k[AW-2:0], 1'b0};
            end
            S_KID_LW: begin
                mem_we = 1'b1;
                mem_wa = {r_k[AW-2:0], 1'b0};
                mem_wd = {nm_rd, rar_pkg::sat_add(pd_rd, r_c)};
                mem_re = 1'b1;
                mem_ra = {r_k[AW-2:0], 1'b1};
            end
            S_KID_RW: begin
                mem_we = 1'b1;
                mem_wa = {r_k[AW-2:0], 1'b1};
                mem_wd = {nm_rd, rar_pkg::sat_add(pd_rd, r_c)};
            end
            S_WRK: begin
                mem_we = 1'b1;
                mem_wd = {nm_fin, {VW{1'b0}}};
            end
            S_RET: begin
                if (r_sp != '0 && r_stk_flag[sp_m1] && r_op == rar_pkg::OP_ADD) begin
                    mem_we = 1'b1;
                    mem_wa = p_k;
                    mem_wd = {p_max, {VW{1'b0}}};
                end
            end
            default: ;
        endcase
    end

    // node memory
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        if (mem_re) r_rd <= r_mem[mem_ra];
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_array_size <= rar_pkg::ARRAY_SIZE_RESET;
        end else if (i_cfg_we) begin
            r_array_size <= i_cfg_wdata;
        end
    end

    // tree walk sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_sp    <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(NC - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (start) begin
                        r_op  <= i_opcode;
                        r_a   <= LW'(i_range_low);
                        r_b   <= LW'(i_range_high);
                        r_v   <= VW'(i_add_value);
                        r_k   <= AW'(1);
                        r_lo  <= LW'(1);
                        r_hi  <= used_n;
                        r_sp  <= '0;
                        r_state <= S_VISIT;
                    end
                end
                S_VISIT: begin
                    r_state <= S_K_WAIT;
                end
                S_K_WAIT: begin
                    r_nm1   <= nm1;
                    r_c     <= c_amt;
                    r_out   <= out_c;
                    r_cover <= cover_c;
                    r_split <= split;
                    r_state <= (kids && c_amt != '0) ? S_KID_L : S_WRK;
                end
                S_KID_L: begin
                    r_state <= S_KID_LW;
                end
                S_KID_LW: begin
                    r_state <= S_KID_RW;
                end
                S_KID_RW: begin
                    r_state <= S_WRK;
                end
                S_WRK: begin
                    if (r_out || r_cover || !r_split) begin
                        r_ret <= (r_op == rar_pkg::OP_MAX && (r_out || !r_cover)) ?
                                 '0 : nm_fin;
                        r_state <= S_RET;
                    end else begin
                        // partial overlap: descend into the left child
                        r_stk_k[r_sp]    <= r_k;
                        r_stk_lo[r_sp]   <= r_lo;
                        r_stk_hi[r_sp]   <= r_hi;
                        r_stk_flag[r_sp] <= 1'b0;
                        r_stk_acc[r_sp]  <= '0;
                        r_sp  <= r_sp + 1'b1;
                        r_k   <= {r_k[AW-2:0], 1'b0};
                        r_hi  <= mid;
                        r_state <= S_VISIT;
                    end
                end
                S_RET: begin
                    if (r_sp == '0) begin
                        o_valid     <= (r_op == rar_pkg::OP_MAX);
                        o_max_value <= r_ret;
                        r_state     <= S_IDLE;
                    end else if (!r_stk_flag[sp_m1]) begin
                        // left done: keep its value, go right
                        r_stk_flag[sp_m1] <= 1'b1;
                        r_stk_acc[sp_m1]  <= r_ret;
                        r_k   <= {p_k[AW-2:0], 1'b1};
                        r_lo  <= p_mid + 1'b1;
                        r_hi  <= p_hi;
                        r_state <= S_VISIT;
                    end else begin
                        // both done: combine and pop
                        r_ret <= p_max;
                        r_sp  <= sp_m1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
